### sv/mef_pkg.sv
`default_nettype none
package mef_pkg;

    localparam logic [5:0] OP_NOP   = 6'd0;
    localparam logic [5:0] OP_SLL   = 6'd1;
    localparam logic [5:0] OP_SRL   = 6'd2;
    localparam logic [5:0] OP_SRA   = 6'd3;
    localparam logic [5:0] OP_JR    = 6'd4;
    localparam logic [5:0] OP_MFHI  = 6'd5;
    localparam logic [5:0] OP_MFLO  = 6'd6;
    localparam logic [5:0] OP_MULT  = 6'd7;
    localparam logic [5:0] OP_MULTU = 6'd8;
    localparam logic [5:0] OP_ADD   = 6'd9;
    localparam logic [5:0] OP_ADDU  = 6'd10;
    localparam logic [5:0] OP_SUB   = 6'd11;
    localparam logic [5:0] OP_AND   = 6'd12;
    localparam logic [5:0] OP_OR    = 6'd13;
    localparam logic [5:0] OP_XOR   = 6'd14;
    localparam logic [5:0] OP_NOR   = 6'd15;
    localparam logic [5:0] OP_NAND  = 6'd16;
    localparam logic [5:0] OP_SLT   = 6'd17;
    localparam logic [5:0] OP_JAL   = 6'd19;
    localparam logic [5:0] OP_ADDI  = 6'd23;
    localparam logic [5:0] OP_ADDIU = 6'd24;
    localparam logic [5:0] OP_SLTI  = 6'd25;
    localparam logic [5:0] OP_ANDI  = 6'd26;
    localparam logic [5:0] OP_ORI   = 6'd27;
    localparam logic [5:0] OP_NORI  = 6'd28;
    localparam logic [5:0] OP_LUI   = 6'd29;
    localparam logic [5:0] OP_LB    = 6'd30;
    localparam logic [5:0] OP_LH    = 6'd31;
    localparam logic [5:0] OP_LW    = 6'd32;
    localparam logic [5:0] OP_LBU   = 6'd33;
    localparam logic [5:0] OP_LHU   = 6'd34;
    localparam logic [5:0] OP_SB    = 6'd35;
    localparam logic [5:0] OP_SH    = 6'd36;
    localparam logic [5:0] OP_SW    = 6'd37;

    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_RD    = 3'd1;
    localparam logic [2:0] K_RT    = 3'd2;
    localparam logic [2:0] K_LOAD  = 3'd3;
    localparam logic [2:0] K_STORE = 3'd4;
    localparam logic [2:0] K_LINK  = 3'd5;

    localparam logic [1:0] SRC_RF = 2'd0;
    localparam logic [1:0] SRC_WB = 2'd1;
    localparam logic [1:0] SRC_EX = 2'd2;

    localparam logic [4:0] LINK_REG = 5'd31;
    localparam logic [31:0] ADDR_BIAS = 32'd8;

    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rs_index;
        logic [4:0]  rt_index;
        logic [4:0]  rd_index;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
        logic [31:0] immediate;
        logic [4:0]  wb_reg;
        logic [31:0] wb_data;
        logic        wb_is_store;
        logic        halt_pending;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result;
        logic [4:0]  dest_reg;
        logic [2:0]  dest_kind;
        logic [31:0] store_data;
        logic [1:0]  fwd_rs_source;
        logic [1:0]  fwd_rt_source;
        logic        overflow;
        logic        hilo_overwrite;
        logic        addr_out_of_range;
        logic        misaligned;
    } out_item_t;

    // forwarding source held by this stage
    typedef struct packed {
        logic [31:0] result;
        logic [4:0]  dest_reg;
        logic [2:0]  dest_kind;
    } held_t;

endpackage
`default_nettype wire

### sv/mips_execute_stage_forwarding_unit.sv
// Execute stage with operand forwarding for a five-stage pipeline.
// Input channel: in_valid/in_stall carry one decoded instruction (in_item_t).
// Output channel: out_valid/out_stall carry one result (out_item_t).
// Every instruction yields exactly one result transaction.
// Each instruction passes through the input register, then the result
// register. Throughput: one instruction per cycle while out_stall is low.
// The held EX/MEM result and HI/LO are updated when an instruction leaves
// the input register, so the next instruction forwards from it directly.
// The multiply is a 32x32 product into HI/LO in the execute cycle.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall rises once both are full, so nothing is lost.
// Reset clears the held result (kind none), HI, LO, the unread flag and
// both valid flags. Data memory spans DATA_MEM_BYTES bytes from address 0;
// issued accesses report address plus 8 in result.
`default_nettype none
module mips_execute_stage_forwarding_unit #(
    parameter int DATA_MEM_BYTES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire mef_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output mef_pkg::out_item_t      out_data
);
    import mef_pkg::*;

    localparam logic [32:0] MEM_LAST = 33'(DATA_MEM_BYTES - 1);

    logic      in_vld_reg;
    in_item_t  in_reg;
    logic      out_vld_reg;
    out_item_t out_reg;
    held_t     held_reg, held_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;
    logic      unread_reg, unread_next;

    logic      fire;
    logic      use_rs, use_rt;
    logic [31:0] rs, rt;
    logic [1:0]  src_rs, src_rt;
    out_item_t   res;
    logic [4:0]  sh;
    logic [31:0] sum, diff, addr;
    logic [32:0] addr_end;
    logic [2:0]  size;
    logic        is_mem, is_store;
    logic [63:0] prod;
    logic        op_use_both, op_use_rs;

    // execute when output slot is free or being drained
    assign fire     = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !fire;

    always_comb
    begin
        op_use_both = (in_reg.op >= OP_MULT && in_reg.op <= OP_SLT)
                      || (in_reg.op >= OP_SB && in_reg.op <= OP_SW);
        op_use_rs   = (in_reg.op >= OP_ADDI && in_reg.op <= OP_NORI)
                      || (in_reg.op >= OP_LB && in_reg.op <= OP_LHU);
        use_rs = op_use_both || op_use_rs;
        use_rt = op_use_both || (in_reg.op >= OP_SLL && in_reg.op <= OP_SRA);
    end

    mef_forward u_fwd_rs (
        .idx(in_reg.rs_index), .reg_value(in_reg.rs_value), .used(use_rs),
        .wb_reg(in_reg.wb_reg), .wb_data(in_reg.wb_data),
        .wb_is_store(in_reg.wb_is_store), .held(held_reg),
        .value(rs), .source(src_rs)
    );

    mef_forward u_fwd_rt (
        .idx(in_reg.rt_index), .reg_value(in_reg.rt_value), .used(use_rt),
        .wb_reg(in_reg.wb_reg), .wb_data(in_reg.wb_data),
        .wb_is_store(in_reg.wb_is_store), .held(held_reg),
        .value(rt), .source(src_rt)
    );

    always_comb
    begin
        sh   = in_reg.immediate[4:0];
        sum  = rs + rt;
        diff = rs - rt;
        addr = rs + in_reg.immediate;
        if (in_reg.op == OP_MULT)
            prod = 64'($signed(rs) * $signed(rt));
        else
            prod = {32'd0, rs} * {32'd0, rt};
        is_mem   = in_reg.op >= OP_LB && in_reg.op <= OP_SW;
        is_store = in_reg.op >= OP_SB;
        case (in_reg.op)
            OP_LH, OP_LHU, OP_SH: size = 3'd2;
            OP_LW, OP_SW:         size = 3'd4;
            default:              size = 3'd1;
        endcase
        addr_end = {1'b0, addr} + 33'(size) - 33'd1;

        res = '0;
        res.fwd_rs_source = src_rs;
        res.fwd_rt_source = src_rt;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        unread_next = unread_reg;

        unique case (in_reg.op)
            OP_SLL: begin res.result = rt << sh; res.dest_kind = K_RD; end
            OP_SRL: begin res.result = rt >> sh; res.dest_kind = K_RD; end
            OP_SRA:
            begin
                res.result = $unsigned($signed(rt) >>> sh);
                res.dest_kind = K_RD;
            end
            OP_MFHI:
            begin
                unread_next = 1'b0; res.result = hi_reg; res.dest_kind = K_RD;
            end
            OP_MFLO:
            begin
                unread_next = 1'b0; res.result = lo_reg; res.dest_kind = K_RD;
            end
            OP_MULT, OP_MULTU:
            begin
                res.hilo_overwrite = unread_reg;
                unread_next = 1'b1;
                hi_next = prod[63:32];
                lo_next = prod[31:0];
            end
            OP_ADD:
            begin
                res.result = sum;
                res.overflow = (rs[31] ^ sum[31]) & (rt[31] ^ sum[31]);
                res.dest_kind = K_RD;
            end
            OP_ADDU: begin res.result = sum; res.dest_kind = K_RD; end
            OP_SUB:
            begin
                res.result = diff;
                res.overflow = (rs[31] ^ rt[31]) & (rs[31] ^ diff[31]);
                res.dest_kind = K_RD;
            end
            OP_AND:  begin res.result = rs & rt; res.dest_kind = K_RD; end
            OP_OR:   begin res.result = rs | rt; res.dest_kind = K_RD; end
            OP_XOR:  begin res.result = rs ^ rt; res.dest_kind = K_RD; end
            OP_NOR:  begin res.result = ~(rs | rt); res.dest_kind = K_RD; end
            OP_NAND: begin res.result = ~(rs & rt); res.dest_kind = K_RD; end
            OP_SLT:
            begin
                res.result = {31'd0, $signed(rs) < $signed(rt)};
                res.dest_kind = K_RD;
            end
            OP_JAL:
            begin
                res.result = {27'd0, in_reg.rt_index};
                res.dest_kind = K_LINK;
            end
            OP_ADDI:
            begin
                res.result = addr;
                res.overflow = (rs[31] ^ addr[31]) & (in_reg.immediate[31] ^ addr[31]);
                res.dest_kind = K_RT;
            end
            OP_ADDIU: begin res.result = addr; res.dest_kind = K_RT; end
            OP_SLTI:
            begin
                res.result = {31'd0, $signed(rs) < $signed(in_reg.immediate)};
                res.dest_kind = K_RT;
            end
            OP_ANDI: begin res.result = rs & in_reg.immediate; res.dest_kind = K_RT; end
            OP_ORI:  begin res.result = rs | in_reg.immediate; res.dest_kind = K_RT; end
            OP_NORI:
            begin
                res.result = ~(rs | in_reg.immediate); res.dest_kind = K_RT;
            end
            OP_LUI:
            begin
                res.result = {in_reg.immediate[15:0], 16'd0}; res.dest_kind = K_RT;
            end
            default: ;
        endcase

        if (is_mem)
        begin
            res.overflow = (rs[31] ^ addr[31]) & (in_reg.immediate[31] ^ addr[31]);
            res.addr_out_of_range = addr[31] || (addr_end > MEM_LAST);
            res.misaligned = (addr[1:0] & (size[1:0] - 2'd1)) != 2'd0
                             || (size[2] && addr[1:0] != 2'd0);
            if (!res.addr_out_of_range && !res.misaligned && !in_reg.halt_pending)
            begin
                res.result = addr + ADDR_BIAS;
                if (is_store)
                begin
                    res.dest_kind  = K_STORE;
                    res.store_data = rt;
                end
                else
                    res.dest_kind = K_LOAD;
            end
        end

        case (res.dest_kind)
            K_RD:           res.dest_reg = in_reg.rd_index;
            K_RT, K_LOAD:   res.dest_reg = in_reg.rt_index;
            K_LINK:         res.dest_reg = LINK_REG;
            default:        res.dest_reg = 5'd0;
        endcase

        held_next.result    = res.result;
        held_next.dest_reg  = res.dest_reg;
        held_next.dest_kind = res.dest_kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            held_reg    <= '0;
            hi_reg      <= '0;
            lo_reg      <= '0;
            unread_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (fire)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
            if (fire)
            begin
                held_reg   <= held_next;
                hi_reg     <= hi_next;
                lo_reg     <= lo_next;
                unread_reg <= unread_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_reg <= in_data;
        if (fire)
            out_reg <= res;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    a_held_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (held_reg.dest_kind == out_data.dest_kind
                       && held_reg.result == out_data.result))
        else $error("held result differs from last issued result");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("result register changed while stalled");

    a_store_no_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.dest_kind == K_STORE) |-> out_data.dest_reg == 5'd0)
        else $error("store carries a destination");

    a_issue_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.addr_out_of_range || out_data.misaligned))
        |-> (out_data.dest_kind == K_NONE))
        else $error("bad access issued");
endmodule
`default_nettype wire

### sv/mef_forward.sv
`default_nettype none
module mef_forward (
    input  wire logic [4:0]     idx,
    input  wire logic [31:0]    reg_value,
    input  wire logic           used,
    input  wire logic [4:0]     wb_reg,
    input  wire logic [31:0]    wb_data,
    input  wire logic           wb_is_store,
    input  wire mef_pkg::held_t held,
    output logic [31:0]         value,
    output logic [1:0]          source
);
    import mef_pkg::*;

    logic ex_hit;
    logic wb_hit;

    always_comb
    begin
        ex_hit = (held.dest_reg == idx) && ((held.dest_kind == K_RD)
                 || (held.dest_kind == K_RT) || (held.dest_kind == K_LINK));
        wb_hit = (wb_reg == idx) && !wb_is_store;
        value  = reg_value;
        source = SRC_RF;
        if (used && idx != 5'd0)
        begin
            if (ex_hit)
            begin
                value  = held.result;
                source = SRC_EX;
            end
            else if (wb_hit)
            begin
                value  = wb_data;
                source = SRC_WB;
            end
        end
    end
endmodule
`default_nettype wire
